// ===== design/pmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsf_pkg
// shared types and constants for the pareto minimal set pair filter
// ----------------------------------------------------------------------------
package pmsf_pkg;

	localparam int FIELD_W   = 64;
	localparam int OUTCOME_W = 2;
	localparam int SLOT_W    = 4;
	localparam int ERASED_W  = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MASK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MASK = 2'd1;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_ADDED     = 2'd0,
		OUT_MERGED    = 2'd1,
		OUT_DISCARDED = 2'd2,
		OUT_FULL      = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	// relation of the new pair to one stored pair
	typedef struct packed {
		logic equal;   // both components equal
		logic sub;     // new pair subset-or-equal of entry in both components
		logic sup;     // new pair superset-or-equal of entry in both components
	} cmp_t;

endpackage

// ===== design/pareto_minimal_set_pair_filter.sv =====
// ----------------------------------------------------------------------------
// pareto_minimal_set_pair_filter
// the done strobe follows the scan of the table, which ends early when a merge
//   or discard is found
// the scan reads one table entry a cycle from the projection memory; a new
//   command is accepted only while busy is low, after the previous scan ends
// reset clears the masks, all valid bits and the controller; the projection
//   memory is not cleared. done is a one-cycle strobe, the receiver cannot stall
// ----------------------------------------------------------------------------
module pareto_minimal_set_pair_filter #(
	parameter int ENTRIES    = 16,
	parameter int MODEL_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command side
	input  logic                              start,
	output logic                              busy,
	input  logic [pmsf_pkg::FIELD_W-1:0]      model_bits,
	// result side
	output logic                              done,
	output logic [pmsf_pkg::OUTCOME_W-1:0]    outcome,
	output logic [pmsf_pkg::SLOT_W-1:0]       slot,
	output logic [pmsf_pkg::ERASED_W-1:0]     erased_slots,
	// configuration write port
	input  logic                              wr_en,
	input  logic [pmsf_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [pmsf_pkg::FIELD_W-1:0]      wr_data
);
	import pmsf_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int EXT_W = IDX_W + SLOT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	// configuration registers
	logic [FIELD_W-1:0] first_mask_q;
	logic [FIELD_W-1:0] second_mask_q;

	// controller
	state_t             state_q;
	logic [IDX_W-1:0]   scan_q;        // read address being issued
	logic               issue_end_q;   // last entry address already issued
	logic               stop_q;        // merge or discard ended the scan
	outcome_t           stop_outcome_q;
	logic [IDX_W-1:0]   hit_q;         // slot of the equal entry
	logic               free_vld_q;    // a free slot was seen during the scan
	logic [IDX_W-1:0]   free_q;        // lowest free slot
	logic [ERASED_W-1:0] erased_q;
	logic [ENTRIES-1:0] valid_q;

	// projected pair of the current transaction
	logic [MODEL_BITS-1:0] p1_q;
	logic [MODEL_BITS-1:0] p2_q;

	// projection memory: {second, first} per entry, registered read
	logic [2*MODEL_BITS-1:0] mem_q [ENTRIES];
	logic [2*MODEL_BITS-1:0] rd_data_s1;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        idx_s1;

	// result registers
	logic                  done_q;
	outcome_t              res_outcome_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic [ERASED_W-1:0]   res_erased_q;

	cmp_t rel;
	logic ent_live;
	logic hit_eq;
	logic hit_sub;
	logic hit_sup;
	logic ent_free;
	logic go_done;
	logic mem_wr;
	logic erase_ok;
	logic [EXT_W-1:0] idx_ext;
	logic [EXT_W-1:0] free_ext;
	logic [EXT_W-1:0] hit_ext;

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign outcome      = res_outcome_q;
	assign slot         = res_slot_q;
	assign erased_slots = res_erased_q;

	// compare the entry read last cycle against the new pair
	pmsf_cmp #(
		.W (MODEL_BITS)
	) u_cmp (
		.new_a (p1_q),
		.new_b (p2_q),
		.ent_a (rd_data_s1[MODEL_BITS-1:0]),
		.ent_b (rd_data_s1[2*MODEL_BITS-1:MODEL_BITS]),
		.rel   (rel)
	);

	always_comb begin
		ent_live = rd_vld_s1 && valid_q[idx_s1];
		hit_eq   = ent_live && rel.equal;
		hit_sub  = ent_live && !rel.equal && rel.sub;
		hit_sup  = ent_live && !rel.equal && !rel.sub && rel.sup;
		// an entry erased now is free for this same pair
		ent_free = rd_vld_s1 && (!valid_q[idx_s1] || hit_sub);
		go_done  = rd_vld_s1 && ((idx_s1 == LAST_IDX) || hit_eq || hit_sup);
		mem_wr   = state_q[2] && !stop_q && free_vld_q;
		// slot numbers narrowed or widened to the 4-bit result fields
		idx_ext  = {{SLOT_W{1'b0}}, idx_s1};
		free_ext = {{SLOT_W{1'b0}}, free_q};
		hit_ext  = {{SLOT_W{1'b0}}, hit_q};
		erase_ok = (idx_ext < EXT_W'(ERASED_W));
	end

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_mask_q  <= '0;
			second_mask_q <= '0;
		end else if (wr_en) begin
			if (wr_index == CFG_FIRST_MASK) begin
				first_mask_q <= wr_data;
			end
			if (wr_index == CFG_SECOND_MASK) begin
				second_mask_q <= wr_data;
			end
		end
	end

	// pair capture at the accepting edge
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			p1_q <= model_bits[MODEL_BITS-1:0] & first_mask_q[MODEL_BITS-1:0];
			p2_q <= model_bits[MODEL_BITS-1:0] & second_mask_q[MODEL_BITS-1:0];
		end
	end

	// projection memory: read every cycle, write the new pair at the finish
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[free_q] <= {p2_q, p1_q};
		end
		rd_data_s1 <= mem_q[scan_q];
	end

	// scan controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			scan_q         <= '0;
			issue_end_q    <= 1'b0;
			stop_q         <= 1'b0;
			stop_outcome_q <= OUT_ADDED;
			hit_q          <= '0;
			free_vld_q     <= 1'b0;
			free_q         <= '0;
			erased_q       <= '0;
			valid_q        <= '0;
			rd_vld_s1      <= 1'b0;
			idx_s1         <= '0;
			done_q         <= 1'b0;
			res_outcome_q  <= OUT_ADDED;
			res_slot_q     <= '0;
			res_erased_q   <= '0;
		end else begin
			// result strobe for the finishing cycle, compare stage fed while scanning
			done_q    <= (state_q == S_DONE);
			rd_vld_s1 <= (state_q == S_SCAN) && !issue_end_q && !go_done;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						scan_q      <= '0;
						issue_end_q <= 1'b0;
						stop_q      <= 1'b0;
						free_vld_q  <= 1'b0;
						erased_q    <= '0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue side: one address a cycle
					if (!issue_end_q) begin
						scan_q <= scan_q + 1'b1;
						if (scan_q == LAST_IDX) begin
							issue_end_q <= 1'b1;
						end
					end
					idx_s1    <= scan_q;
					// compare side
					if (hit_eq) begin
						stop_q         <= 1'b1;
						stop_outcome_q <= OUT_MERGED;
						hit_q          <= idx_s1;
					end
					if (hit_sup) begin
						stop_q         <= 1'b1;
						stop_outcome_q <= OUT_DISCARDED;
					end
					if (hit_sub) begin
						valid_q[idx_s1] <= 1'b0;
						if (erase_ok) begin
							erased_q[idx_ext[SLOT_W-1:0]] <= 1'b1;
						end
					end
					if (ent_free && !free_vld_q) begin
						free_vld_q <= 1'b1;
						free_q     <= idx_s1;
					end
					if (go_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					res_erased_q <= erased_q;
					priority if (stop_q) begin
						res_outcome_q <= stop_outcome_q;
						res_slot_q    <= (stop_outcome_q == OUT_MERGED) ?
						                 hit_ext[SLOT_W-1:0] : '0;
					end else if (free_vld_q) begin
						valid_q[free_q] <= 1'b1;
						res_outcome_q   <= OUT_ADDED;
						res_slot_q      <= free_ext[SLOT_W-1:0];
					end else begin
						res_outcome_q <= OUT_FULL;
						res_slot_q    <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// every finished scan delivers exactly one result
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> done)
		else $error("busy dropped without a result strobe");

	// a result never overlaps a running scan
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while scan still running");

	// an accepted command starts a scan
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted command did not start a scan");

	// compare stage only runs during the scan
	assert property (@(posedge clk) disable iff (!arst_n) rd_vld_s1 |-> state_q == S_SCAN)
		else $error("compare stage active outside the scan");

	// discarded and table-full results carry slot zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (outcome == OUT_DISCARDED || outcome == OUT_FULL)) |-> slot == '0)
		else $error("nonzero slot on discard or full result");

endmodule

// ===== design/pmsf_cmp.sv =====
// ----------------------------------------------------------------------------
// pmsf_cmp
// subset, superset and equality relations between the new projected pair and one stored pair
// ----------------------------------------------------------------------------
module pmsf_cmp #(
	parameter int W = 64
) (
	input  logic [W-1:0]     new_a,
	input  logic [W-1:0]     new_b,
	input  logic [W-1:0]     ent_a,
	input  logic [W-1:0]     ent_b,
	output pmsf_pkg::cmp_t   rel
);
	import pmsf_pkg::*;

	always_comb begin
		rel.equal = (new_a == ent_a) && (new_b == ent_b);
		rel.sub   = ((new_a & ~ent_a) == '0) && ((new_b & ~ent_b) == '0);
		rel.sup   = ((ent_a & ~new_a) == '0) && ((ent_b & ~new_b) == '0);
	end

endmodule
